>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the decimal text converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define B2DA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the antecedent is followed by the consequent in the next cycle.
`define B2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // Widths of the external word fields
  localparam int unsigned ValueBits = 64;
  localparam int unsigned CharBits  = 6;
  localparam int unsigned DigitBits = 4;

  // ASCII code of '0', which fits in the character field
  localparam logic [CharBits-1:0] AsciiZero = 6'd48;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } b2da_state_e;

  // Per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clear;        // zero the digit at the start of a conversion
    logic shift_bit;    // double dabble step: adjust then shift one bit in
    logic shift_digit;  // move whole digits one cell toward the top
  } b2da_cell_ctrl_t;

endpackage

>>> rtl/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell
// One BCD digit of the double dabble chain. Adds three when the digit is five
// or more, then shifts in one bit from the lower cell; can also take over the
// whole digit of the lower cell when the result is unloaded.
// ----------------------------------------------------------------------------
module b2da_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  b2da_pkg::b2da_cell_ctrl_t              ctrl_i,
  input  logic                                   bit_i,
  input  logic [b2da_pkg::DigitBits-1:0]         digit_i,
  output logic                                   carry_o,
  output logic [b2da_pkg::DigitBits-1:0]         digit_o
);
  import b2da_pkg::*;

  logic [DigitBits-1:0] digit_q, digit_d;
  logic [DigitBits-1:0] adj;

  // Add-3 correction ahead of the shift
  always_comb begin
    adj = (digit_q >= DigitBits'(5)) ? digit_q + DigitBits'(3) : digit_q;
  end

  assign carry_o = adj[DigitBits-1];
  assign digit_o = digit_q;

  // Next digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift_bit) begin
      digit_d = {adj[DigitBits-2:0], bit_i};
    end else if (ctrl_i.shift_digit) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

>>> rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Converts an unsigned binary word to its decimal text, one ASCII digit per
// output word, most significant first, leading zeros dropped.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i, in_ready_o, value_i  | input word
//   out     | out_valid_o, out_ready_i,        | one digit per word
//           | digit_char_o, last_o             |
//
// A word passes through the accept state, VALUE_WIDTH shift steps through the
// digit cell chain, the dropping of leading zeros, a hand-over from dropping
// zeros to unloading, and the unloading of the digits.
// One word is in flight at a time; in_ready_o is high only when idle.
// Output stalls hold the current digit; nothing to clear after reset.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [b2da_pkg::ValueBits-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [b2da_pkg::CharBits-1:0]     digit_char_o,
  output logic                              last_o
);
  import b2da_pkg::*;

  // Decimal digits of 2^VALUE_WIDTH - 1
  localparam int unsigned NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned RemW      = $clog2(NumDigits + 1);

  b2da_state_e            state_q, state_d;
  logic [BitCntW-1:0]     bit_cnt_q, bit_cnt_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   load;
  b2da_cell_ctrl_t        ctrl;

  logic [DigitBits-1:0]   digit [NumDigits];
  logic                   carry [NumDigits];
  logic [DigitBits-1:0]   top_digit;

  assign top_digit = digit[NumDigits-1];

  // Digit cell chain, least significant digit in cell 0
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    logic                 bit_in;
    logic [DigitBits-1:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = val_q[VALUE_WIDTH-1];
      assign digit_in = '0;
    end else begin : g_next
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    b2da_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  // Controller: next state, counters and cell commands
  always_comb begin
    state_d          = state_q;
    bit_cnt_d        = bit_cnt_q;
    rem_d            = rem_q;
    load             = 1'b0;
    ctrl             = '0;
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load       = 1'b1;
          ctrl.clear = 1'b1;
          bit_cnt_d  = BitCntW'(VALUE_WIDTH);
          state_d    = StConv;
        end
      end
      StConv: begin
        ctrl.shift_bit = 1'b1;
        bit_cnt_d      = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == BitCntW'(1)) begin
          rem_d   = RemW'(NumDigits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, keeping at least one digit
        if (top_digit == '0 && rem_q != RemW'(1)) begin
          ctrl.shift_digit = 1'b1;
          rem_d            = rem_q - RemW'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctrl.shift_digit = 1'b1;
          rem_d            = rem_q - RemW'(1);
          if (rem_q == RemW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign digit_char_o = AsciiZero + {{(CharBits-DigitBits){1'b0}}, top_digit};
  assign last_o       = (rem_q == RemW'(1));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      rem_q     <= rem_d;
    end
  end

  // Input shift register, MSB feeds the chain
  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= value_i[VALUE_WIDTH-1:0];
    end else if (ctrl.shift_bit) begin
      val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
    end
  end

endmodule

>>> rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b2da_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] digit_char_o,
  input logic       last_o
);

  // a stalled output word holds
  `B2DA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(digit_char_o) && $stable(last_o), "output word changed under stall")

  // every character is an ASCII decimal digit
  `B2DA_ASSERT(a_digit_range, clk_i, rst_ni, !out_valid_o || (digit_char_o >= 6'd48 && digit_char_o <= 6'd57), "digit out of range")

  // one word in flight: no input taken while digits are offered
  `B2DA_ASSERT(a_one_word, clk_i, rst_ni, !(in_ready_o && out_valid_o), "input ready while emitting")

  // conversion needs cycles before the first digit
  `B2DA_ASSERT_NEXT(a_conv_delay, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o, "digit right after accept")

  // the run ends after the last digit
  `B2DA_ASSERT_NEXT(a_run_end, clk_i, rst_ni, out_valid_o && out_ready_i && last_o, !out_valid_o && in_ready_o, "run continued after last")

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_o       (last_o)
);
